// ===== rtl/core/lpf_pkg.sv =====
// lpf_pkg: shared types and constants for the longest palindrome finder
// no dependencies; imported by lpf_cell, longest_palindrome_finder, lpf_result_checker and the test
`default_nettype none

package lpf_pkg;

  localparam int CHAR_W  = 8;
  localparam int START_W = 6;
  localparam int LEN_W   = 7;

  // controller states, one-hot
  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_START = 4'b0010,
    S_EVAL  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic start;  // seed the row for length 1
    logic step;   // advance the row by one substring length
    logic clear;  // drop stored bytes for the next string
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpf_cell.sv =====
// lpf_cell: one position of the string, holds its byte and the palindrome bits
// for the substring starting here; depends on lpf_pkg
`default_nettype none

module lpf_cell
  import lpf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctl_t         ctl,
  input  wire logic              wr_en,
  input  wire logic [CHAR_W-1:0] char_in,
  // from the right-hand neighbor
  input  wire logic [CHAR_W-1:0] nb_c,
  input  wire logic              nb_v,
  input  wire logic [CHAR_W-1:0] nb_d,
  input  wire logic              nb_vd,
  input  wire logic              nb_prev,
  // own state, seen by the left-hand neighbor and the sequencer
  output logic      [CHAR_W-1:0] c,
  output logic                   v,
  output logic      [CHAR_W-1:0] d,
  output logic                   vd,
  output logic                   prev,
  output logic                   cur
);

  // stored byte and its valid bit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      c <= char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      v <= 1'b0;
    end else if (wr_en) begin
      v <= 1'b1;
    end
  end

  // d is the byte at the far end of the next, longer substring; it travels left
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      d    <= nb_c;
      vd   <= nb_v;
      cur  <= v;
      prev <= 1'b1;
    end else if (ctl.step) begin
      cur  <= (c == d) && vd && nb_prev;
      prev <= cur;
      d    <= nb_d;
      vd   <= nb_vd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/longest_palindrome_finder.sv =====
// longest_palindrome_finder: top level, byte loader, row of lpf_cell and sequencer
// sequence: the load words, then a seed step, a length sweep and a scan,
// the last of them loading the output register
// throughput: one string at a time; a stalled output holds the scan and the input
// reset: rst is synchronous, active high; clears count, overflow, valid bits, state
// depends on lpf_pkg and lpf_cell
`default_nettype none

module longest_palindrome_finder
  import lpf_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CHAR_W-1:0] char_in,
  input  wire logic              last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [START_W-1:0]     best_start,
  output logic [LEN_W-1:0]       best_length,
  output logic                   overflow
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  state_t             state;
  logic [CNT_W-1:0]   count;     // bytes stored for this string
  logic               ovf;       // a byte was dropped
  logic [CNT_W-1:0]   k;         // substring length now held in the row
  logic [CNT_W-1:0]   best_len;
  logic [MAX_LEN-1:0] best_vec;  // start positions of palindromes of length best_len
  logic [IDX_W-1:0]   pos;       // scan position over best_vec

  logic [START_W-1:0] res_start;
  logic [LEN_W-1:0]   res_len;
  logic               res_ovf;

  cell_ctl_t          ctl;
  logic [MAX_LEN-1:0] wr_en;

  // per-cell state, collected so that each cell sees its right-hand neighbor
  logic [CHAR_W-1:0]  c_q [MAX_LEN];
  logic [CHAR_W-1:0]  d_q [MAX_LEN];
  logic [MAX_LEN-1:0] v_q;
  logic [MAX_LEN-1:0] vd_q;
  logic [MAX_LEN-1:0] prev_q;
  logic [MAX_LEN-1:0] cur_q;

  logic in_acc;
  logic store_byte;
  logic scan_done;
  logic any_pal;

  assign in_ready   = (state == S_LOAD);
  assign in_acc     = in_valid && in_ready;
  assign store_byte = in_acc && (count < CNT_W'(MAX_LEN));
  assign any_pal    = |cur_q;
  // the scan finishes on the first set bit, but only once the output register is free
  assign scan_done  = (state == S_SCAN) && best_vec[0] && (!out_valid || out_ready);

  always_comb begin
    ctl.start = (state == S_START);
    ctl.step  = (state == S_EVAL) && (k != count);
    ctl.clear = scan_done;
  end

  // byte write decode: the count selects the cell
  genvar gi;
  generate
    for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
      assign wr_en[gi] = store_byte && (count[IDX_W-1:0] == IDX_W'(gi));

      if (gi == MAX_LEN - 1) begin : g_end
        // past the end of the row nothing is valid
        lpf_cell u_cell (
          .clk     (clk),
          .rst     (rst),
          .ctl     (ctl),
          .wr_en   (wr_en[gi]),
          .char_in (char_in),
          .nb_c    ('0),
          .nb_v    (1'b0),
          .nb_d    ('0),
          .nb_vd   (1'b0),
          .nb_prev (1'b0),
          .c       (c_q[gi]),
          .v       (v_q[gi]),
          .d       (d_q[gi]),
          .vd      (vd_q[gi]),
          .prev    (prev_q[gi]),
          .cur     (cur_q[gi])
        );
      end else begin : g_mid
        lpf_cell u_cell (
          .clk     (clk),
          .rst     (rst),
          .ctl     (ctl),
          .wr_en   (wr_en[gi]),
          .char_in (char_in),
          .nb_c    (c_q[gi+1]),
          .nb_v    (v_q[gi+1]),
          .nb_d    (d_q[gi+1]),
          .nb_vd   (vd_q[gi+1]),
          .nb_prev (prev_q[gi+1]),
          .c       (c_q[gi]),
          .v       (v_q[gi]),
          .d       (d_q[gi]),
          .vd      (vd_q[gi]),
          .prev    (prev_q[gi]),
          .cur     (cur_q[gi])
        );
      end
    end
  endgenerate

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (store_byte) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;  // string longer than the row, byte dropped
            end
            if (last) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          // row holds length k; stop after the full string length
          if (k == count) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_LOAD;
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // length sweep bookkeeping; longer lengths come later, so the latest hit wins
  always_ff @(posedge clk) begin
    if (state == S_START) begin
      k        <= CNT_W'(1);
      best_len <= '0;
      pos      <= '0;
    end else if (state == S_EVAL) begin
      k <= k + CNT_W'(1);
      if (any_pal) begin
        best_len <= k;
        best_vec <= cur_q;
      end
    end else if ((state == S_SCAN) && !best_vec[0]) begin
      // walk toward the earliest start, one position per cycle
      best_vec <= best_vec >> 1;
      pos      <= pos + IDX_W'(1);
    end
  end

  // output register, parted from the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      res_start <= START_W'(pos);
      res_len   <= LEN_W'(best_len);
      res_ovf   <= ovf;
    end
  end

  assign best_start  = res_start;
  assign best_length = res_len;
  assign overflow    = res_ovf;

  // the stored count never runs past the row
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_LEN))
    else $error("byte count beyond row length");

  // a scan always has at least one palindrome start to find
  assert property (@(posedge clk) disable iff (rst) (state == S_SCAN) |-> (best_vec != '0))
    else $error("scan with no palindrome recorded");

  // the sweep never goes past the string length
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> ((k != '0) && (k <= count)))
    else $error("length sweep out of range");

  // a result is only produced with a nonzero length
  assert property (@(posedge clk) disable iff (rst) scan_done |-> (best_len != '0))
    else $error("result with zero length");

endmodule

`default_nettype wire

// ===== dv/lpf_result_checker.sv =====
// lpf_result_checker: watches both channels of longest_palindrome_finder,
// predicts each result and compares it; depends on lpf_pkg
`timescale 1ns / 100ps

module lpf_result_checker
  import lpf_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [CHAR_W-1:0]  char_in,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [START_W-1:0] best_start,
  input  logic [LEN_W-1:0]   best_length,
  input  logic               overflow,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic [START_W-1:0] first_idx;
    logic [LEN_W-1:0]   span_len;
    logic               truncated;
  } span_t;

  logic [CHAR_W-1:0] string_bytes [MAX_LEN];
  int                byte_count;
  logic              bytes_dropped;
  span_t             expected_spans [$];
  int                error_count;

  initial begin
    byte_count    = 0;
    bytes_dropped = 1'b0;
    error_count   = 0;
    errors        = 0;
    pending       = 0;
  end

  // grow a palindrome from every center in order; for one length a later
  // center always means a later start, so strict > keeps the earliest start
  function automatic void find_longest_span(input int n, output int s_best,
                                            output int l_best);
    int lo, hi;
    s_best = 0;
    l_best = 0;
    for (int c = 0; c < 2 * n - 1; c++) begin
      lo = c / 2;
      hi = lo + (c % 2);
      while (lo >= 0 && hi < n && string_bytes[lo] == string_bytes[hi]) begin
        lo--;
        hi++;
      end
      if (hi - lo - 1 > l_best) begin
        l_best = hi - lo - 1;
        s_best = lo + 1;
      end
    end
  endfunction

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    int    s, l;
    span_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_spans.size() == 0) begin
          $display("%0t: result with no string pending: start %0d length %0d overflow %0b",
                   $time, best_start, best_length, overflow);
          error_count++;
        end else begin
          want = expected_spans.pop_front();
          compare_field("best_start", want.first_idx, best_start);
          compare_field("best_length", want.span_len, best_length);
          compare_field("overflow", want.truncated, overflow);
        end
      end
      if (in_valid && in_ready) begin
        if (byte_count < MAX_LEN) begin
          string_bytes[byte_count] = char_in;
          byte_count++;
        end else begin
          bytes_dropped = 1'b1;
        end
        if (last) begin
          find_longest_span(byte_count, s, l);
          want.first_idx = START_W'(s);
          want.span_len  = LEN_W'(l);
          want.truncated = bytes_dropped;
          expected_spans.push_back(want);
          byte_count    = 0;
          bytes_dropped = 1'b0;
        end
      end
    end
    errors  <= error_count;
    pending <= expected_spans.size();
  end

endmodule

// ===== dv/longest_palindrome_finder_test.sv =====
// longest_palindrome_finder_test: stimulus and verdict for longest_palindrome_finder
// depends on lpf_pkg, longest_palindrome_finder and lpf_result_checker
`timescale 1ns / 100ps

module longest_palindrome_finder_test;
  import lpf_pkg::*;

  localparam int MAX_LEN      = 64;
  localparam int RANDOM_WORDS = 800;
  // drain wait after the last result, with margin
  localparam int DRAIN_CYCLES = 4 * MAX_LEN + 16;

  typedef logic [CHAR_W-1:0] word_q_t [$];

  // how the bytes of a random string are chosen
  typedef enum int {
    FILL_NOISE,     // any byte value
    FILL_TWO_SYM,   // two symbols, lots of short palindromes
    FILL_THREE_SYM, // three symbols plus a mirrored segment
    FILL_MIRROR     // same, kept separate to weight mirrored strings up
  } fill_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [CHAR_W-1:0]  char_in;
  logic               last;
  logic               out_valid;
  logic               out_ready;
  logic [START_W-1:0] best_start;
  logic [LEN_W-1:0]   best_length;
  logic               overflow;

  int   errors;
  int   pending;
  logic steady; // no idling on either side while set

  int words_sent;
  int strings_sent;
  int strings_cut;

  always #5 clk = ~clk;

  longest_palindrome_finder #(.MAX_LEN(MAX_LEN)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .best_start (best_start),
    .best_length(best_length),
    .overflow   (overflow)
  );

  lpf_result_checker #(.MAX_LEN(MAX_LEN)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .best_start (best_start),
    .best_length(best_length),
    .overflow   (overflow),
    .errors     (errors),
    .pending    (pending)
  );

  // result side: stall about a third of the time except in the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 32);
  end

  // one word: optional idle cycles first, then hold valid until accepted;
  // valid is not lowered before the word is accepted, and the caller drops it at the end
  task automatic send_word(input logic [CHAR_W-1:0] ch, input logic is_last);
    while (!steady && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= ch;
    last     <= is_last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_string(input word_q_t str);
    for (int i = 0; i < str.size(); i++) begin
      send_word(str[i], i == str.size() - 1);
    end
    words_sent += str.size();
    strings_sent++;
    if (str.size() > MAX_LEN) begin
      strings_cut++;
    end
  endtask

  // random content; small alphabets and mirrored segments make long
  // palindromes and ties common, noise exercises every bit of the byte
  function automatic word_q_t make_string(input int n);
    word_q_t           s;
    logic [CHAR_W-1:0] alpha [3];
    fill_t             fill;
    int                lo, hi;
    fill = fill_t'($urandom_range(3));
    foreach (alpha[k]) begin
      alpha[k] = CHAR_W'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      if (fill == FILL_NOISE) begin
        s.push_back(CHAR_W'($urandom));
      end else begin
        s.push_back(alpha[$urandom_range(fill == FILL_TWO_SYM ? 1 : 2)]);
      end
    end
    // copy one half of a random segment onto the other
    if ((fill == FILL_THREE_SYM || fill == FILL_MIRROR) && n > 1) begin
      lo = $urandom_range(n - 1);
      hi = $urandom_range(n - 1, lo);
      while (lo < hi) begin
        s[hi] = s[lo];
        lo++;
        hi--;
      end
    end
    return s;
  endfunction

  initial begin
    int random_words;
    int str_idx;
    int n_len;

    rst          = 1'b1;
    in_valid     = 1'b0;
    char_in      = '0;
    last         = 1'b0;
    out_ready    = 1'b0;
    steady       = 1'b0;
    words_sent   = 0;
    strings_sent = 0;
    strings_cut  = 0;
    random_words = 0;
    str_idx      = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings
    send_string('{8'h00});                                 // one byte only
    send_string('{8'hff, 8'hff});                          // equal pair
    send_string('{8'h00, 8'hff});                          // unequal pair, length 1 wins
    send_string('{8'h55, 8'haa, 8'h55});                   // odd palindrome
    send_string('{8'h12, 8'h34, 8'h34, 8'h12, 8'h99});     // even palindrome at start
    send_string('{8'h01, 8'h02, 8'h01, 8'h03, 8'h04, 8'h03}); // tie, earliest start
    send_string('{8'h07, 8'h08, 8'h09, 8'h09});           // only the final pair matches

    // random strings; the first three hit exactly full, one dropped byte
    // (the final one) and several dropped bytes
    while (random_words < RANDOM_WORDS) begin
      if (str_idx == 0) begin
        n_len = MAX_LEN;
      end else if (str_idx == 1) begin
        n_len = MAX_LEN + 1;
      end else if (str_idx == 2) begin
        n_len = MAX_LEN + 6;
      end else if ($urandom_range(19) == 0) begin
        n_len = $urandom_range(MAX_LEN + 8, MAX_LEN - 4);
      end else begin
        n_len = $urandom_range(16, 1);
      end
      steady <= (str_idx >= 12 && str_idx < 30);
      send_string(make_string(n_len));
      random_words += n_len;
      str_idx++;
    end
    in_valid <= 1'b0;

    // drain: let the checker count the last string, wait for every result,
    // then quiet time for anything unexpected
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words in %0d strings, %0d of them longer than %0d bytes",
             words_sent, strings_sent, strings_cut, MAX_LEN);
    if (errors == 0 && pending == 0) begin
      $display("longest_palindrome_finder verification clean");
    end else begin
      $display("longest_palindrome_finder verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("longest_palindrome_finder verification failed");
    $finish;
  end

endmodule
